// ===== hdl/hdlc_afsk_modulator_macros.svh =====
// ----------------------------------------------------------------------------
// HDLC AFSK modulator assertion macros
// Shared property forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef HDLC_AFSK_MODULATOR_MACROS_SVH
`define HDLC_AFSK_MODULATOR_MACROS_SVH

// Same-cycle implication, disabled in reset
`define HAFSK_ASSERT_NOW(lbl, clk, rstn, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, disabled in reset
`define HAFSK_ASSERT_NEXT(lbl, clk, rstn, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== hdl/hafsk_pkg.sv =====
// ----------------------------------------------------------------------------
// HDLC AFSK modulator package
// Constants, types, sine table and phase wrap shared by the modulator files.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hafsk_pkg;

    localparam int TABLE_SIZE        = 48;
    localparam int SAMPLES_PER_BIT   = 8;
    localparam int ONES_BEFORE_STUFF = 5;
    localparam int SAMPLE_BITS       = 8;

    localparam int PHASE_W   = $clog2(TABLE_SIZE);
    localparam int STEP_W    = 6;
    localparam int BIT_CNT_W = $clog2(SAMPLES_PER_BIT);
    localparam int ONES_W    = $clog2(ONES_BEFORE_STUFF + 1);
    localparam int BYTE_W    = 8;
    localparam int CFG_IDX_W = 3;

    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 24;

    localparam logic [BYTE_W-1:0] FLAG_BYTE = 8'h7E;

    typedef logic [PHASE_W-1:0]     phase_t;
    typedef logic [SAMPLE_BITS-1:0] sample_t;

    typedef enum logic [1:0] {
        PH_PREAMBLE = 2'd0,
        PH_BEGIN    = 2'd1,
        PH_DATA     = 2'd2,
        PH_END      = 2'd3
    } frame_phase_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MARK_STEP      = 3'd0,
        REG_SPACE_STEP     = 3'd1,
        REG_PREAMBLE_FLAGS = 3'd2,
        REG_LOOPBACK       = 3'd3,
        REG_DAC_MASK       = 3'd4,
        REG_IDLE_CODE      = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic arm;
        logic bit_strobe;
    } frm_ctrl_t;

    typedef struct packed {
        logic              frame_pending;
        logic              head_valid;
        logic [BYTE_W-1:0] head_byte;
        logic              head_last;
    } frm_head_t;

    typedef struct packed {
        logic tone_is_mark;
        logic taken;
        logic wind;
    } frm_stat_t;

    function automatic sample_t sine_at(phase_t idx);
        sample_t v;
        unique case (idx)
            6'd0:  v = 8'h80;  6'd1:  v = 8'h90;  6'd2:  v = 8'ha0;  6'd3:  v = 8'hb0;
            6'd4:  v = 8'hbf;  6'd5:  v = 8'hcd;  6'd6:  v = 8'hda;  6'd7:  v = 8'he5;
            6'd8:  v = 8'hee;  6'd9:  v = 8'hf5;  6'd10: v = 8'hfb;  6'd11: v = 8'hfe;
            6'd12: v = 8'hff;  6'd13: v = 8'hfe;  6'd14: v = 8'hfb;  6'd15: v = 8'hf5;
            6'd16: v = 8'hee;  6'd17: v = 8'he5;  6'd18: v = 8'hda;  6'd19: v = 8'hcd;
            6'd20: v = 8'hbf;  6'd21: v = 8'hb0;  6'd22: v = 8'ha0;  6'd23: v = 8'h90;
            6'd24: v = 8'h80;  6'd25: v = 8'h6f;  6'd26: v = 8'h5f;  6'd27: v = 8'h4f;
            6'd28: v = 8'h40;  6'd29: v = 8'h32;  6'd30: v = 8'h25;  6'd31: v = 8'h1a;
            6'd32: v = 8'h11;  6'd33: v = 8'h0a;  6'd34: v = 8'h04;  6'd35: v = 8'h01;
            6'd36: v = 8'h00;  6'd37: v = 8'h01;  6'd38: v = 8'h04;  6'd39: v = 8'h0a;
            6'd40: v = 8'h11;  6'd41: v = 8'h1a;  6'd42: v = 8'h25;  6'd43: v = 8'h32;
            6'd44: v = 8'h40;  6'd45: v = 8'h4f;  6'd46: v = 8'h5f;  6'd47: v = 8'h6f;
            default: v = '0;
        endcase
        return v;
    endfunction

    // Phase plus step stays below three table lengths
    function automatic phase_t phase_wrap(logic [PHASE_W:0] sum);
        phase_t v;
        if (sum >= (PHASE_W+1)'(2 * TABLE_SIZE)) begin
            v = PHASE_W'(sum - (PHASE_W+1)'(2 * TABLE_SIZE));
        end else if (sum >= (PHASE_W+1)'(TABLE_SIZE)) begin
            v = PHASE_W'(sum - (PHASE_W+1)'(TABLE_SIZE));
        end else begin
            v = PHASE_W'(sum);
        end
        return v;
    endfunction

endpackage

// ===== hdl/hafsk_framer.sv =====
// ----------------------------------------------------------------------------
// HDLC bit framer
// Makes one HDLC bit per strobe (none on the strobe that starts the wind-down):
// preamble, flags, stuffed LSB-first data, and keeps the NRZI tone.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hafsk_framer (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  hafsk_pkg::frm_ctrl_t         ctrl,
    input  hafsk_pkg::frm_head_t         head,
    input  logic [hafsk_pkg::BYTE_W-1:0] preamble_flags,
    output hafsk_pkg::frm_stat_t         stat
);

    hafsk_pkg::frame_phase_t             phase_reg, phase_next;
    logic [hafsk_pkg::BYTE_W-1:0]        shift_reg, shift_next;
    logic [2:0]                          bitpos_reg, bitpos_next;
    logic [hafsk_pkg::ONES_W-1:0]        ones_reg, ones_next;
    logic                                pend_reg, pend_next;
    logic                                allow_reg, allow_next;
    logic [hafsk_pkg::BYTE_W-1:0]        pre_left_reg, pre_left_next;
    logic                                mark_reg, mark_next;
    logic                                wind_c, taken_c, tx_bit;
    logic [hafsk_pkg::ONES_W-1:0]        ones_inc;

    always_comb begin
        phase_next    = phase_reg;
        shift_next    = shift_reg;
        allow_next    = allow_reg;
        pre_left_next = pre_left_reg;
        wind_c        = 1'b0;
        taken_c       = 1'b0;
        if (bitpos_reg == 3'd0 && !pend_reg) begin
            unique case (phase_reg)
                hafsk_pkg::PH_PREAMBLE: begin
                    shift_next = hafsk_pkg::FLAG_BYTE;
                    allow_next = 1'b0;
                    if (pre_left_reg <= hafsk_pkg::BYTE_W'(1)) begin
                        pre_left_next = '0;
                        phase_next    = hafsk_pkg::PH_BEGIN;
                    end else begin
                        pre_left_next = pre_left_reg - hafsk_pkg::BYTE_W'(1);
                    end
                end
                hafsk_pkg::PH_BEGIN: begin
                    if (head.frame_pending) begin
                        shift_next = hafsk_pkg::FLAG_BYTE;
                        allow_next = 1'b0;
                        phase_next = hafsk_pkg::PH_DATA;
                    end else begin
                        phase_next = hafsk_pkg::PH_PREAMBLE;
                        wind_c     = 1'b1;
                    end
                end
                hafsk_pkg::PH_DATA: begin
                    if (head.head_valid) begin
                        shift_next = head.head_byte;
                        allow_next = 1'b1;
                        taken_c    = 1'b1;
                        if (head.head_last) begin
                            phase_next = hafsk_pkg::PH_END;
                        end
                    end else begin
                        shift_next = hafsk_pkg::FLAG_BYTE;
                        allow_next = 1'b0;
                        phase_next = hafsk_pkg::PH_END;
                    end
                end
                hafsk_pkg::PH_END: begin
                    shift_next = hafsk_pkg::FLAG_BYTE;
                    allow_next = 1'b0;
                    phase_next = hafsk_pkg::PH_BEGIN;
                end
                default: begin
                    phase_next = hafsk_pkg::PH_PREAMBLE;
                end
            endcase
        end
    end

    always_comb begin
        ones_inc    = ones_reg + hafsk_pkg::ONES_W'(1);
        bitpos_next = bitpos_reg;
        ones_next   = ones_reg;
        pend_next   = pend_reg;
        if (pend_reg) begin
            tx_bit    = 1'b0;
            pend_next = 1'b0;
        end else begin
            tx_bit = shift_next[bitpos_reg];
            if (tx_bit) begin
                if (ones_inc >= hafsk_pkg::ONES_W'(hafsk_pkg::ONES_BEFORE_STUFF)) begin
                    ones_next = '0;
                    pend_next = allow_next;
                end else begin
                    ones_next = ones_inc;
                end
            end else begin
                ones_next = '0;
            end
            bitpos_next = bitpos_reg + 3'd1;
        end
        mark_next = tx_bit ? mark_reg : !mark_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= hafsk_pkg::PH_PREAMBLE;
            shift_reg    <= hafsk_pkg::FLAG_BYTE;
            bitpos_reg   <= '0;
            ones_reg     <= '0;
            pend_reg     <= 1'b0;
            allow_reg    <= 1'b0;
            pre_left_reg <= '0;
            mark_reg     <= 1'b1;
        end else if (ctrl.arm) begin
            mark_reg     <= 1'b1;
            shift_reg    <= hafsk_pkg::FLAG_BYTE;
            bitpos_reg   <= '0;
            pre_left_reg <= preamble_flags;
            allow_reg    <= 1'b0;
            pend_reg     <= 1'b0;
            ones_reg     <= '0;
        end else if (ctrl.bit_strobe) begin
            phase_reg <= phase_next;
            if (!wind_c) begin
                shift_reg    <= shift_next;
                allow_reg    <= allow_next;
                pre_left_reg <= pre_left_next;
                bitpos_reg   <= bitpos_next;
                ones_reg     <= ones_next;
                pend_reg     <= pend_next;
                mark_reg     <= mark_next;
            end
        end
    end

    assign stat.tone_is_mark = mark_reg;
    assign stat.taken        = ctrl.bit_strobe & taken_c;
    assign stat.wind         = ctrl.bit_strobe & wind_c;

endmodule

// ===== hdl/hdlc_afsk_modulator.sv =====
// An input transfer is captured in the input register; its result is registered in
// the result register on m_axis. Throughput: one item per cycle while m_axis is
// ready; phase add, table read and framer step sit between the two registers.
// Reset (aresetn low, synchronous) clears both stages, loads the register
// defaults and leaves the transmitter idle on the mark tone.
// ----------------------------------------------------------------------------
// HDLC AFSK modulator
// Sine-table AFSK sample generator driven by an HDLC framer, one result per
// input item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hdlc_afsk_modulator (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [0] frame_pending, [1] head_valid, [9:2] head_byte, [15:10] zero
    input  logic [hafsk_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // [0] kind
    input  logic [0:0]                      s_axis_tuser,
    input  logic                            s_axis_tlast,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [7:0] dac_code, [15:8] loop_sample, [16] byte_taken, [17] idle, [23:18] zero
    output logic [hafsk_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [hafsk_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [hafsk_pkg::BYTE_W-1:0]    cfg_data
);

    localparam int M_PAD_W = hafsk_pkg::M_TDATA_W - 2 * hafsk_pkg::BYTE_W - 2;

    // configuration
    logic [hafsk_pkg::STEP_W-1:0] mark_step_reg, space_step_reg;
    logic [hafsk_pkg::BYTE_W-1:0] preamble_reg, dac_mask_reg, idle_code_reg;
    logic                         loopback_reg;

    // input stage
    logic                            in_valid_reg;
    logic [hafsk_pkg::S_TDATA_W-1:0] in_data_reg;
    logic                            in_kind_reg, in_last_reg;

    // modulator state
    hafsk_pkg::phase_t               tone_phase_reg, tone_phase_next;
    hafsk_pkg::phase_t               test_phase_reg, test_phase_next;
    logic                            ready_reg, ready_next;
    logic                            winding_reg, winding_next;
    logic [hafsk_pkg::BIT_CNT_W-1:0] sample_cnt_reg, sample_cnt_next;

    // result stage
    logic                            out_valid_reg;
    logic [hafsk_pkg::M_TDATA_W-1:0] out_data_reg;

    logic                            advance, tick_active, bit_end, wind_end;
    logic [hafsk_pkg::STEP_W-1:0]    tone_step;
    hafsk_pkg::phase_t               tone_adv, test_adv;
    hafsk_pkg::sample_t              tone_sample, test_sample;
    logic [hafsk_pkg::BYTE_W-1:0]    dac_next, loop_next;
    hafsk_pkg::frm_ctrl_t            frm_ctrl;
    hafsk_pkg::frm_head_t            frm_head;
    hafsk_pkg::frm_stat_t            frm_stat;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign cfg_ready     = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mark_step_reg  <= hafsk_pkg::STEP_W'(6);
            space_step_reg <= hafsk_pkg::STEP_W'(11);
            preamble_reg   <= 8'd30;
            loopback_reg   <= 1'b0;
            dac_mask_reg   <= 8'hFF;
            idle_code_reg  <= 8'h80;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                hafsk_pkg::REG_MARK_STEP:      mark_step_reg  <= cfg_data[hafsk_pkg::STEP_W-1:0];
                hafsk_pkg::REG_SPACE_STEP:     space_step_reg <= cfg_data[hafsk_pkg::STEP_W-1:0];
                hafsk_pkg::REG_PREAMBLE_FLAGS: preamble_reg   <= cfg_data;
                hafsk_pkg::REG_LOOPBACK:       loopback_reg   <= cfg_data[0];
                hafsk_pkg::REG_DAC_MASK:       dac_mask_reg   <= cfg_data;
                hafsk_pkg::REG_IDLE_CODE:      idle_code_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            in_data_reg <= s_axis_tdata;
            in_kind_reg <= s_axis_tuser[0];
            in_last_reg <= s_axis_tlast;
        end
    end

    assign frm_head.frame_pending = in_data_reg[0];
    assign frm_head.head_valid    = in_data_reg[1];
    assign frm_head.head_byte     = in_data_reg[9:2];
    assign frm_head.head_last     = in_last_reg;

    assign tick_active = !in_kind_reg && !ready_reg;
    assign tone_step   = frm_stat.tone_is_mark ? mark_step_reg : space_step_reg;
    assign tone_adv    = hafsk_pkg::phase_wrap({1'b0, tone_phase_reg} + {1'b0, tone_step});
    assign test_adv    = hafsk_pkg::phase_wrap({1'b0, test_phase_reg} + {1'b0, mark_step_reg});
    assign tone_sample = hafsk_pkg::sine_at(tone_phase_reg);
    assign test_sample = hafsk_pkg::sine_at(test_phase_reg);
    assign bit_end     = sample_cnt_reg ==
                         hafsk_pkg::BIT_CNT_W'(hafsk_pkg::SAMPLES_PER_BIT - 1);
    assign wind_end    = winding_reg && (tone_adv < space_step_reg);

    assign frm_ctrl.arm        = advance && in_kind_reg && ready_reg;
    assign frm_ctrl.bit_strobe = advance && tick_active && !winding_reg && bit_end;

    always_comb begin
        dac_next  = idle_code_reg;
        loop_next = idle_code_reg;
        if (tick_active) begin
            if (loopback_reg) begin
                dac_next  = test_sample & dac_mask_reg;
                loop_next = tone_sample;
            end else begin
                dac_next  = tone_sample & dac_mask_reg;
            end
            if (wind_end) begin
                dac_next = idle_code_reg;
            end
        end
    end

    always_comb begin
        tone_phase_next = tone_phase_reg;
        test_phase_next = test_phase_reg;
        ready_next      = ready_reg;
        winding_next    = winding_reg;
        sample_cnt_next = sample_cnt_reg;
        if (frm_ctrl.arm) begin
            ready_next = 1'b0;
        end else if (advance && tick_active) begin
            if (loopback_reg) begin
                test_phase_next = test_adv;
            end
            if (winding_reg) begin
                if (wind_end) begin
                    tone_phase_next = '0;
                    ready_next      = 1'b1;
                    winding_next    = 1'b0;
                end else begin
                    tone_phase_next = tone_adv;
                end
            end else begin
                tone_phase_next = tone_adv;
                sample_cnt_next = bit_end ? '0 : sample_cnt_reg + hafsk_pkg::BIT_CNT_W'(1);
                if (frm_stat.wind) begin
                    winding_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tone_phase_reg <= '0;
            test_phase_reg <= '0;
            ready_reg      <= 1'b1;
            winding_reg    <= 1'b0;
            sample_cnt_reg <= '0;
        end else begin
            tone_phase_reg <= tone_phase_next;
            test_phase_reg <= test_phase_next;
            ready_reg      <= ready_next;
            winding_reg    <= winding_next;
            sample_cnt_reg <= sample_cnt_next;
        end
    end

    hafsk_framer u_framer (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .ctrl           (frm_ctrl),
        .head           (frm_head),
        .preamble_flags (preamble_reg),
        .stat           (frm_stat)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= {M_PAD_W'(0), ready_next, frm_stat.taken, loop_next, dac_next};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

// ===== hdl/hafsk_checker.sv =====
// ----------------------------------------------------------------------------
// HDLC AFSK modulator port checker
// Watches the stream ports of the modulator over time; bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "hdlc_afsk_modulator_macros.svh"

module hafsk_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [hafsk_pkg::M_TDATA_W-1:0] m_axis_tdata
);

    `HAFSK_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

    `HAFSK_ASSERT_NOW(a_in_open, aclk, aresetn, !m_axis_tvalid, s_axis_tready, "input stalled with empty result stage")

    `HAFSK_ASSERT_NOW(a_out_cause, aclk, aresetn, $rose(m_axis_tvalid), $past(s_axis_tvalid && s_axis_tready, 2), "result without an input transfer")

    `HAFSK_ASSERT_NOW(a_taken_busy, aclk, aresetn, m_axis_tvalid && m_axis_tdata[16], !m_axis_tdata[17], "byte taken on an idle result")

endmodule

bind hdlc_afsk_modulator hafsk_checker u_hafsk_checker (.*);

// ===== bench/hdlc_afsk_modulator_checker.sv =====
// ----------------------------------------------------------------------------
// HDLC AFSK modulator stream checker
// Watches the configuration, input and result channels. Keeps its own copy
// of the tone, framer and register state, works out the sample for every
// input transfer and compares each result transfer with the oldest one due.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hdlc_afsk_modulator_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    input  logic                            s_ready,
    input  logic [hafsk_pkg::S_TDATA_W-1:0] s_data,
    input  logic [0:0]                      s_user,
    input  logic                            s_last,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  logic [hafsk_pkg::M_TDATA_W-1:0] m_data,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [hafsk_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [hafsk_pkg::BYTE_W-1:0]    cfg_data,
    output int                              fail_count,
    output int                              outstanding
);
    import hafsk_pkg::*;

    localparam logic [48*8-1:0] SINE_ROM = {
        8'h80, 8'h90, 8'ha0, 8'hb0, 8'hbf, 8'hcd, 8'hda, 8'he5,
        8'hee, 8'hf5, 8'hfb, 8'hfe, 8'hff, 8'hfe, 8'hfb, 8'hf5,
        8'hee, 8'he5, 8'hda, 8'hcd, 8'hbf, 8'hb0, 8'ha0, 8'h90,
        8'h80, 8'h6f, 8'h5f, 8'h4f, 8'h40, 8'h32, 8'h25, 8'h1a,
        8'h11, 8'h0a, 8'h04, 8'h01, 8'h00, 8'h01, 8'h04, 8'h0a,
        8'h11, 8'h1a, 8'h25, 8'h32, 8'h40, 8'h4f, 8'h5f, 8'h6f
    };

    typedef struct packed {
        logic       idle;
        logic       taken;
        logic [7:0] echo;
        logic [7:0] dac;
    } afsk_sample_t;

    // register copies
    logic [5:0]   mark_step;
    logic [5:0]   space_step;
    logic [7:0]   preamble_cfg;
    logic         loop_en;
    logic [7:0]   dac_mask;
    logic [7:0]   idle_code;

    // modulator and framer state
    logic [5:0]   tone_phase;
    logic [5:0]   test_phase;
    logic         tone_mark;
    logic         tx_ready;
    logic         winding;
    int           sample_cnt;
    frame_phase_t fphase;
    logic [7:0]   shifter;
    logic [2:0]   bit_idx;
    int           ones_cnt;
    logic         stuff_due;
    logic         stuff_ok;
    int           preamble_cnt;

    afsk_sample_t due_q[$];

    function automatic logic [7:0] sine_sample(input logic [5:0] idx);
        return SINE_ROM[(TABLE_SIZE - 1 - int'(idx)) * 8 +: 8];
    endfunction

    function automatic logic [5:0] phase_add(input logic [5:0] p, input logic [5:0] s);
        return 6'((int'(p) + int'(s)) % TABLE_SIZE);
    endfunction

    task automatic modulate(input logic kind, input logic fp, input logic hv,
                            input logic [7:0] hb, input logic hl,
                            output afsk_sample_t r);
        logic [7:0] dac;
        logic [7:0] echo;
        logic       taken;
        logic       quit;
        logic       b;
        dac   = idle_code;
        echo  = idle_code;
        taken = 1'b0;
        quit  = 1'b0;
        if (kind) begin
            if (tx_ready) begin
                tone_mark    = 1'b1;
                shifter      = FLAG_BYTE;
                bit_idx      = '0;
                preamble_cnt = int'(preamble_cfg);
                stuff_ok     = 1'b0;
                stuff_due    = 1'b0;
                ones_cnt     = 0;
                tx_ready     = 1'b0;
            end
        end else if (!tx_ready) begin
            if (loop_en) begin
                dac        = sine_sample(test_phase) & dac_mask;
                test_phase = phase_add(test_phase, mark_step);
                echo       = sine_sample(tone_phase);
            end else begin
                dac = sine_sample(tone_phase) & dac_mask;
            end
            tone_phase = phase_add(tone_phase, tone_mark ? mark_step : space_step);

            if (winding) begin
                if (tone_phase < space_step) begin
                    tone_phase = '0;
                    tx_ready   = 1'b1;
                    winding    = 1'b0;
                    dac        = idle_code;
                end
            end else begin
                sample_cnt++;
                if (sample_cnt >= SAMPLES_PER_BIT) begin
                    sample_cnt = 0;
                    if (bit_idx == 3'd0 && !stuff_due) begin
                        case (fphase)
                            PH_PREAMBLE: begin
                                shifter  = FLAG_BYTE;
                                stuff_ok = 1'b0;
                                if (preamble_cnt <= 1) begin
                                    preamble_cnt = 0;
                                    fphase       = PH_BEGIN;
                                end else begin
                                    preamble_cnt--;
                                end
                            end
                            PH_BEGIN: begin
                                if (fp) begin
                                    shifter  = FLAG_BYTE;
                                    stuff_ok = 1'b0;
                                    fphase   = PH_DATA;
                                end else begin
                                    fphase  = PH_PREAMBLE;
                                    winding = 1'b1;
                                    quit    = 1'b1;
                                end
                            end
                            PH_DATA: begin
                                if (hv) begin
                                    shifter  = hb;
                                    stuff_ok = 1'b1;
                                    taken    = 1'b1;
                                    if (hl) begin
                                        fphase = PH_END;
                                    end
                                end else begin
                                    // empty pop: flag, then close
                                    shifter  = FLAG_BYTE;
                                    stuff_ok = 1'b0;
                                    fphase   = PH_END;
                                end
                            end
                            default: begin
                                shifter  = FLAG_BYTE;
                                stuff_ok = 1'b0;
                                fphase   = PH_BEGIN;
                            end
                        endcase
                    end

                    if (!quit) begin
                        if (stuff_due) begin
                            b         = 1'b0;
                            stuff_due = 1'b0;
                        end else begin
                            b = shifter[bit_idx];
                            if (b) begin
                                ones_cnt++;
                                if (ones_cnt >= ONES_BEFORE_STUFF) begin
                                    ones_cnt  = 0;
                                    stuff_due = stuff_ok;
                                end
                            end else begin
                                ones_cnt = 0;
                            end
                            bit_idx = bit_idx + 3'd1;
                        end
                        if (!b) begin
                            tone_mark = !tone_mark;
                        end
                    end
                end
            end
        end
        r.dac   = dac;
        r.echo  = echo;
        r.taken = taken;
        r.idle  = tx_ready;
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            fail_count++;
            if (fail_count <= 10) begin
                $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $realtime, name,
                         want, got);
            end
        end
    endtask

    initial begin
        fail_count  = 0;
        outstanding = 0;
    end

    always @(posedge aclk) begin
        afsk_sample_t want;
        afsk_sample_t got;
        afsk_sample_t next;
        if (!aresetn) begin
            mark_step    = 6'd6;
            space_step   = 6'd11;
            preamble_cfg = 8'd30;
            loop_en      = 1'b0;
            dac_mask     = 8'hFF;
            idle_code    = 8'h80;
            tone_phase   = '0;
            test_phase   = '0;
            tone_mark    = 1'b1;
            tx_ready     = 1'b1;
            winding      = 1'b0;
            sample_cnt   = 0;
            fphase       = PH_PREAMBLE;
            shifter      = FLAG_BYTE;
            bit_idx      = '0;
            ones_cnt     = 0;
            stuff_due    = 1'b0;
            stuff_ok     = 1'b0;
            preamble_cnt = 0;
            due_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_MARK_STEP:      mark_step    = cfg_data[5:0];
                    REG_SPACE_STEP:     space_step   = cfg_data[5:0];
                    REG_PREAMBLE_FLAGS: preamble_cfg = cfg_data;
                    REG_LOOPBACK:       loop_en      = cfg_data[0];
                    REG_DAC_MASK:       dac_mask     = cfg_data;
                    REG_IDLE_CODE:      idle_code    = cfg_data;
                    default: ;
                endcase
            end

            if (m_valid && m_ready) begin
                got = afsk_sample_t'(m_data[17:0]);
                if (due_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("%0t: unexpected result 0x%0h", $realtime, m_data);
                    end
                end else begin
                    want = due_q.pop_front();
                    check_field("dac_code", int'(want.dac), int'(got.dac));
                    check_field("loop_sample", int'(want.echo), int'(got.echo));
                    check_field("byte_taken", int'(want.taken), int'(got.taken));
                    check_field("idle", int'(want.idle), int'(got.idle));
                end
            end

            if (s_valid && s_ready) begin
                modulate(s_user[0], s_data[0], s_data[1], s_data[9:2], s_last, next);
                due_q.push_back(next);
            end
        end
        outstanding = due_q.size();
    end

endmodule

// ===== bench/hdlc_afsk_modulator_tb.sv =====
// ----------------------------------------------------------------------------
// HDLC AFSK modulator testbench
// Drives start requests and sample ticks with buffer-head contents through
// several register settings and idling patterns; the checker beside the
// block predicts every sample and reports the mismatch count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hdlc_afsk_modulator_tb;
    import hafsk_pkg::*;

    localparam int STALL_LIMIT = 5000;
    localparam int DRAIN_CAP   = 20000;
    localparam int PHASE_ITEMS = 260;
    localparam int IDLE_BIT    = 17;

    logic                   aclk          = 1'b0;
    logic                   aresetn       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [S_TDATA_W-1:0]   s_axis_tdata  = '0;
    logic [0:0]             s_axis_tuser  = '0;
    logic                   s_axis_tlast  = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_axis_tdata;
    logic                   cfg_valid     = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index     = '0;
    logic [BYTE_W-1:0]      cfg_data      = '0;

    int   fail_count;
    int   outstanding;
    int   send_gap_pct = 0;
    int   recv_gap_pct = 0;
    int   hold_len     = 0;
    int   hold_left    = 0;
    int   quiet_cycles = 0;
    int   sent_items   = 0;
    logic last_idle    = 1'b1;

    always #4 aclk = ~aclk;

    hdlc_afsk_modulator dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    hdlc_afsk_modulator_checker afsk_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_axis_tvalid),
        .s_ready     (s_axis_tready),
        .s_data      (s_axis_tdata),
        .s_user      (s_axis_tuser),
        .s_last      (s_axis_tlast),
        .m_valid     (m_axis_tvalid),
        .m_ready     (m_axis_tready),
        .m_data      (m_axis_tdata),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    // result side: random stalls, or a long hold when asked
    always @(negedge aclk) begin
        if (hold_len > 0) begin
            hold_left = hold_len;
            hold_len  = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= recv_gap_pct);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            last_idle <= 1'b1;
        end else if (m_axis_tvalid && m_axis_tready) begin
            last_idle <= m_axis_tdata[IDLE_BIT];
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("hdlc_afsk_modulator_tb NOT OK");
                $finish;
            end
        end
    end

    task automatic send_item(input logic kind, input logic fp, input logic hv,
                             input logic [7:0] hb, input logic hl);
        @(negedge aclk);
        while ($urandom_range(0, 99) < send_gap_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {6'b0, hb, hv, fp};
        s_axis_tlast  <= hl;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        sent_items++;
    endtask

    task automatic pause_sender();
        @(negedge aclk);
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (outstanding != 0) @(negedge aclk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [7:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic apply_setting(input logic [5:0] mark, input logic [5:0] space,
                                 input logic [7:0] flags, input logic loop_on,
                                 input logic [7:0] mask, input logic [7:0] rest_code);
        write_reg(REG_MARK_STEP, 8'(mark));
        write_reg(REG_SPACE_STEP, 8'(space));
        write_reg(REG_PREAMBLE_FLAGS, flags);
        write_reg(REG_LOOPBACK, 8'(loop_on));
        write_reg(REG_DAC_MASK, mask);
        write_reg(REG_IDLE_CODE, rest_code);
    endtask

    // close the frame with ticks that hold no pending frame until the transmitter reports idle
    task automatic settle();
        int spent;
        spent = 0;
        pause_sender();
        wait_drained();
        while (!last_idle) begin
            if (spent > DRAIN_CAP) begin
                $display("hdlc_afsk_modulator_tb NOT OK");
                $finish;
            end
            repeat (16) begin
                send_item(1'b0, 1'b0, $urandom_range(0, 7) == 0, 8'($urandom),
                          1'($urandom_range(0, 1)));
            end
            spent += 16;
            pause_sender();
            wait_drained();
        end
    endtask

    task automatic run_frames(input int budget);
        int         first;
        int         len;
        int         fp_pct;
        logic       kind;
        logic       fp;
        logic       hv;
        logic       hl;
        logic [7:0] hb;
        first = sent_items;
        while (sent_items - first < budget) begin
            fp_pct = ($urandom_range(0, 3) == 0) ? 40 : 96;
            len    = $urandom_range(120, 420);
            send_item(1'b1, 1'b1, 1'($urandom_range(0, 1)), 8'($urandom),
                      1'($urandom_range(0, 1)));
            for (int j = 0; j < len && sent_items - first < budget; j++) begin
                kind = ($urandom_range(0, 99) < 3);
                fp   = ($urandom_range(0, 99) < fp_pct);
                hv   = ($urandom_range(0, 99) < 88);
                hl   = ($urandom_range(0, 99) < 22);
                case ($urandom_range(0, 5))
                    0:       hb = 8'hFF;
                    1:       hb = 8'hF8;
                    2:       hb = FLAG_BYTE;
                    3:       hb = 8'h1F;
                    default: hb = 8'($urandom);
                endcase
                send_item(kind, fp, hv, hb, hl);
            end
            settle();
        end
    endtask

    initial begin
        logic [4:0] sel;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        send_gap_pct = 32;
        recv_gap_pct = 73;
        apply_setting(6'd6, 6'd11, 8'd0, 1'b0, 8'hFF, 8'h80);

        // idle ticks, start, ignored starts, head field extremes
        for (int i = 0; i < 22; i++) begin
            sel = 5'(i);
            send_item(i == 2 || i == 3 || i == 14, sel[0], sel[1],
                      sel[3] ? 8'hFF : 8'h00, sel[2]);
        end
        settle();

        apply_setting(6'd47, 6'd1, 8'd1, 1'b1, 8'h00, 8'h00);
        run_frames(PHASE_ITEMS);

        send_gap_pct = 73;
        recv_gap_pct = 32;
        apply_setting(6'd1, 6'd47, 8'd2, 1'b0, 8'hA5, 8'hFF);
        run_frames(PHASE_ITEMS);
        apply_setting(6'd8, 6'd12, 8'd3, 1'b1, 8'hFF, 8'h5A);
        run_frames(PHASE_ITEMS);

        send_gap_pct = 0;
        recv_gap_pct = 0;
        apply_setting(6'd12, 6'd24, 8'd4, 1'b0, 8'hFF, 8'h3C);
        run_frames(1);
        apply_setting(6'd23, 6'd5, 8'd0, 1'b1, 8'h3C, 8'hC3);
        hold_len = 400;
        run_frames(PHASE_ITEMS);

        pause_sender();
        wait_drained();
        repeat (8) @(posedge aclk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("hdlc_afsk_modulator_tb OK");
        end else begin
            $display("hdlc_afsk_modulator_tb NOT OK");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/hafsk_pkg.sv
hdl/hafsk_framer.sv
hdl/hdlc_afsk_modulator.sv
hdl/hafsk_checker.sv
bench/hdlc_afsk_modulator_checker.sv
bench/hdlc_afsk_modulator_tb.sv
